// File: hdl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CAP_W  = 5;
   localparam int unsigned DATA_W = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(DEPTH);
   localparam logic [DATA_W-1:0] WORD_NONE  = '1;

   // Request codes. Codes above the last one act as a peek.
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_REAR   = 3'd3;
   localparam logic [2:0] REQ_PEEK       = 3'd4;

   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] push_value;
   } cdq_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } cdq_rsp_type;

   // Advance an index by one, wrapping at the active capacity.
   function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] nxt;
      begin
         nxt = CAP_W'(idx) + CAP_W'(1);
         inc_wrap = (nxt >= cap) ? '0 : nxt[IDX_W-1:0];
      end
   endfunction

   // Step an index back by one, wrapping to the last active entry.
   function automatic logic [IDX_W-1:0] dec_wrap(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] last;
      begin
         last = cap - CAP_W'(1);
         if (idx == '0 || CAP_W'(idx) >= cap) begin
            dec_wrap = last[IDX_W-1:0];
         end else begin
            dec_wrap = idx - IDX_W'(1);
         end
      end
   endfunction

endpackage

`default_nettype wire

// File: hdl/circular_deque.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  cdq_req_type (req_type, push_value)
// rsp_      out        rsp_valid / rsp_ready  cdq_rsp_type (status .. is_full)
// csr_      in         csr_we, no wait        csr_wdata = capacity
//
// One request is taken per cycle while req_ready is high; the response passes
// the middle stage, then the response register. The index update happens at the
// accept edge, and the front and rear words come out of the store's registered
// read ports in the following cycle. Reset is synchronous: empty deque, both
// indices zero, capacity 16. A stalled response holds the middle stage, and
// req_ready drops only while both stages are full and rsp_ready is low.

module circular_deque (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire cdq_pkg::cdq_req_type         req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output cdq_pkg::cdq_rsp_type              rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [cdq_pkg::CAP_W-1:0]    csr_wdata
);

   import cdq_pkg::*;

   // Architectural state.
   logic [CAP_W-1:0]  cap_ff;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  rear_ff, rear_in;
   logic              empty_ff, empty_in;

   // Middle stage: everything of the response except the front and rear words.
   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_status_ff, s1_status_in;
   logic [DATA_W-1:0] s1_popped_ff, s1_popped_in;
   logic              s1_empty_ff;
   logic              s1_full_ff, s1_full_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   cdq_rsp_type       rsp_ff;

   // Store and its write-through bypass.
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] ram_q_front, ram_q_rear;
   logic              hit_front_ff, hit_rear_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [DATA_W-1:0] front_word, rear_word;

   logic [CAP_W-1:0]  eff_cap;
   logic              accept, s1_move, full_now;

   // A capacity of zero behaves as one; anything above the store depth saturates.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         eff_cap = CAP_W'(DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
   end

   // The middle stage always drains when the response register is free, so a
   // new request is refused only when both later stages are occupied and stuck.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Read ports hold the front and rear words, save just after a capacity write.
   // A write at the same edge as the read is forwarded from wdata_ff.
   assign front_word = hit_front_ff ? wdata_ff : ram_q_front;
   assign rear_word  = hit_rear_ff  ? wdata_ff : ram_q_rear;

   assign full_now = !empty_ff && (front_ff == inc_wrap(rear_ff, eff_cap));

   // Request processing: index update, store write, status and popped word.
   always_comb begin
      front_in     = front_ff;
      rear_in      = rear_ff;
      empty_in     = empty_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      s1_status_in = STAT_DONE;
      s1_popped_in = WORD_NONE;

      if (accept) begin
         case (req_data.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
               if (full_now) begin
                  s1_status_in = STAT_FULL;
               end else if (empty_ff) begin
                  // The first word always lands in entry zero.
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b0;
                  wr_en    = 1'b1;
                  wr_addr  = '0;
               end else if (req_data.req_type == REQ_PUSH_FRONT) begin
                  front_in = dec_wrap(front_ff, eff_cap);
                  wr_en    = 1'b1;
                  wr_addr  = front_in;
               end else begin
                  rear_in  = inc_wrap(rear_ff, eff_cap);
                  wr_en    = 1'b1;
                  wr_addr  = rear_in;
               end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
               if (empty_ff) begin
                  s1_status_in = STAT_EMPTY;
               end else if (front_ff == rear_ff) begin
                  // The last word leaves; the indices go back to zero.
                  s1_popped_in = front_word;
                  front_in     = '0;
                  rear_in      = '0;
                  empty_in     = 1'b1;
               end else if (req_data.req_type == REQ_POP_FRONT) begin
                  s1_popped_in = front_word;
                  front_in     = inc_wrap(front_ff, eff_cap);
               end else begin
                  s1_popped_in = rear_word;
                  rear_in      = dec_wrap(rear_ff, eff_cap);
               end
            end
            default: begin
               // Peek and the unused codes leave the deque alone.
            end
         endcase
      end

      s1_full_in = !empty_in && (front_in == inc_wrap(rear_in, eff_cap));
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control state. Capacity write clears deque; user: idle only, not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_front_ff <= 1'b0;
         hit_rear_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff   <= csr_wdata;
            front_ff <= '0;
            rear_ff  <= '0;
            empty_ff <= 1'b1;
         end else begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            empty_ff <= empty_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_front_ff <= wr_en && (wr_addr == front_in);
         hit_rear_ff  <= wr_en && (wr_addr == rear_in);
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wdata_ff <= req_data.push_value;
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_popped_ff <= s1_popped_in;
         s1_empty_ff  <= empty_in;
         s1_full_ff   <= s1_full_in;
      end
      if (s1_move) begin
         rsp_ff.status       <= s1_status_ff;
         rsp_ff.popped_value <= s1_popped_ff;
         rsp_ff.front_value  <= s1_empty_ff ? WORD_NONE : front_word;
         rsp_ff.rear_value   <= s1_empty_ff ? WORD_NONE : rear_word;
         rsp_ff.is_empty     <= s1_empty_ff;
         rsp_ff.is_full      <= s1_full_ff;
      end
   end

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.push_value),
      .rd_addr_a (front_in),
      .rd_addr_b (rear_in),
      .rd_data_a (ram_q_front),
      .rd_data_b (ram_q_rear)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/cdq_ram.sv
`default_nettype none

// Simple RAM with one write port and two registered read ports.
module cdq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire
